// ----- rtl/core/rcv_pkg.sv -----
`default_nettype none
package rcv_pkg;

  localparam logic [7:0] CharZero = 8'h30;  // '0'
  localparam logic [7:0] CharA    = 8'h41;  // 'A'
  localparam logic [7:0] CharDot  = 8'h2E;  // '.'

  localparam logic [4:0] BaseMin       = 5'd2;
  localparam logic [4:0] BaseMax       = 5'd16;
  localparam logic [4:0] FracDigitsMax = 5'd20;

  typedef struct packed {
    logic [31:0] int_part;
    logic [31:0] frac_part;
    logic [4:0]  base;
  } rcv_in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } rcv_out_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CharZero + {4'd0, d};
    end else begin
      c = CharA + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/radix_string_converter.sv -----
`default_nettype none
// Converts an unsigned INT_BITS.FRAC_BITS number to ASCII digits in base 2..16,
// most significant first, one character per out_valid_o strobe with last set on
// the final one. The receiver cannot stall: characters must be taken as shown.
// start is taken while busy is low. Integer digits come from a bit-serial
// divider (a zero integer part skips it and stores the single digit '0');
// they are then read back from the digit store. When the fraction is nonzero,
// the '.' and then the fraction digits follow, up to the digit limit. The
// output follows the state by one register stage.
// cfg_ready_o is always high; write only while idle.
module radix_string_converter import rcv_pkg::*; #(
  parameter int INT_BITS  = 32,
  parameter int FRAC_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire rcv_in_t    in_i,
  output logic            out_valid_o,
  output rcv_out_t        out_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [4:0] cfg_data_i
);

  localparam int AddrW = (INT_BITS > 1) ? $clog2(INT_BITS) : 1;
  localparam int CntW  = $clog2(INT_BITS + 1);

  localparam logic [2:0] SIdle    = 3'd0;
  localparam logic [2:0] SDivWait = 3'd1;
  localparam logic [2:0] SRead    = 3'd2;
  localparam logic [2:0] SOut     = 3'd3;
  localparam logic [2:0] SDot     = 3'd4;
  localparam logic [2:0] SFrac    = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [4:0]          cfg_limit_q;
  logic [4:0]          base_q, limit_q, left_q, left_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [AddrW-1:0]    rd_idx_q, rd_idx_d;
  logic [3:0]          rdata_q;
  logic [3:0]          store_q [INT_BITS];
  logic                out_valid_q, out_valid_d;
  rcv_out_t            out_q, out_d;

  logic [4:0]          base_sat, limit_sat;
  logic [INT_BITS-1:0] int_in;
  logic                accept;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [3:0]          wr_data;

  logic                div_go, div_done;
  logic [INT_BITS-1:0] div_dividend, div_quot;
  logic [4:0]          div_base;
  logic [3:0]          div_rem;

  logic                frac_step, frac_zero, frac_next_zero;
  logic [3:0]          frac_digit;

  assign accept    = start && (state_q == SIdle);
  assign int_in    = in_i.int_part[INT_BITS-1:0];
  assign base_sat  = (in_i.base < BaseMin) ? BaseMin :
                     (in_i.base > BaseMax) ? BaseMax : in_i.base;
  assign limit_sat = (cfg_limit_q > FracDigitsMax) ? FracDigitsMax : cfg_limit_q;

  assign div_go       = (accept && (int_in != '0)) ||
                        ((state_q == SDivWait) && div_done && (div_quot != '0));
  assign div_dividend = (state_q == SIdle) ? int_in : div_quot;
  assign div_base     = (state_q == SIdle) ? base_sat : base_q;

  rcv_div #(.INT_BITS(INT_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go),
    .dividend_i (div_dividend),
    .base_i     (div_base),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  rcv_fmul #(.FRAC_BITS(FRAC_BITS)) u_fmul (
    .clk_i       (clk_i),
    .load_i      (accept),
    .frac_i      (in_i.frac_part),
    .step_i      (frac_step),
    .base_i      (base_q),
    .zero_o      (frac_zero),
    .digit_o     (frac_digit),
    .next_zero_o (frac_next_zero)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    left_d      = left_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[AddrW-1:0];
    wr_data     = div_rem;
    frac_step   = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (start) begin
          count_d = '0;
          if (int_in == '0) begin
            // zero integer part is the single digit '0'
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '0;
            count_d  = CntW'(1);
            rd_idx_d = '0;
            state_d  = SRead;
          end else begin
            state_d = SDivWait;
          end
        end
      end
      SDivWait: begin
        if (div_done) begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          if (div_quot == '0) begin
            rd_idx_d = count_q[AddrW-1:0];
            state_d  = SRead;
          end
        end
      end
      SRead: begin
        state_d = SOut;
      end
      SOut: begin
        out_valid_d     = 1'b1;
        out_d.char_code = digit_char(rdata_q);
        out_d.last      = (rd_idx_q == '0) && frac_zero;
        if (rd_idx_q != '0) begin
          rd_idx_d = rd_idx_q - 1'b1;
          state_d  = SRead;
        end else begin
          state_d = frac_zero ? SIdle : SDot;
        end
      end
      SDot: begin
        out_valid_d     = 1'b1;
        out_d.char_code = CharDot;
        out_d.last      = (limit_q == '0);
        left_d          = limit_q;
        state_d         = (limit_q == '0) ? SIdle : SFrac;
      end
      SFrac: begin
        out_valid_d     = 1'b1;
        frac_step       = 1'b1;
        out_d.char_code = digit_char(frac_digit);
        out_d.last      = frac_next_zero || (left_q == 5'd1);
        left_d          = left_q - 1'b1;
        if (out_d.last) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cfg_limit_q <= FracDigitsMax;
      count_q     <= '0;
      rd_idx_q    <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cfg_limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      base_q  <= base_sat;
      limit_q <= limit_sat;
    end
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    if (state_q == SRead) begin
      rdata_q <= store_q[rd_idx_q];
    end
  end

  assign busy        = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;

endmodule
`default_nettype wire

// ----- rtl/core/rcv_div.sv -----
`default_nettype none
// Bit-serial restoring divider: one quotient bit per cycle.
module rcv_div import rcv_pkg::*; #(
  parameter int INT_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                go_i,
  input  wire logic [INT_BITS-1:0] dividend_i,
  input  wire logic [4:0]          base_i,
  output logic                     done_o,
  output logic [INT_BITS-1:0]      quot_o,
  output logic [3:0]               rem_o
);

  localparam int CntW = (INT_BITS > 1) ? $clog2(INT_BITS) : 1;

  logic [INT_BITS-1:0] acc_q, acc_d;
  logic [3:0]          rem_q, rem_d;
  logic [4:0]          base_q;
  logic [CntW-1:0]     cnt_q;
  logic                run_q, done_q;
  logic [4:0]          rem_shift;
  logic                ge;

  always_comb begin
    rem_shift = {rem_q, acc_q[INT_BITS-1]};
    ge        = (rem_shift >= base_q);
    rem_d     = ge ? 4'(rem_shift - base_q) : rem_shift[3:0];
    acc_d     = {acc_q[INT_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(INT_BITS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      acc_q  <= dividend_i;
      rem_q  <= '0;
      base_q <= base_i;
    end else if (run_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- rtl/core/rcv_fmul.sv -----
`default_nettype none
// Fraction register; each step multiplies by the base and peels off one digit.
module rcv_fmul import rcv_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        load_i,
  input  wire logic [31:0] frac_i,
  input  wire logic        step_i,
  input  wire logic [4:0]  base_i,
  output logic             zero_o,
  output logic [3:0]       digit_o,
  output logic             next_zero_o
);

  localparam int ProdW = FRAC_BITS + 5;

  logic [FRAC_BITS-1:0] frac_q;
  logic [FRAC_BITS-1:0] aligned;
  logic [ProdW-1:0]     prod;

  if (FRAC_BITS > 32) begin : g_wide
    assign aligned = FRAC_BITS'(frac_i) << (FRAC_BITS - 32);
  end else if (FRAC_BITS == 32) begin : g_same
    assign aligned = frac_i;
  end else begin : g_narrow
    assign aligned = frac_i[31 -: FRAC_BITS];
  end

  assign prod        = ProdW'(frac_q) * ProdW'(base_i);
  assign digit_o     = prod[FRAC_BITS+3:FRAC_BITS];
  assign next_zero_o = (prod[FRAC_BITS-1:0] == '0);
  assign zero_o      = (frac_q == '0);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frac_q <= aligned;
    end else if (step_i) begin
      frac_q <= prod[FRAC_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_radix_string_converter.sv -----
`timescale 1ns / 1ps
module tb_radix_string_converter;
  import rcv_pkg::*;

  localparam int CycleLimit  = 2_000_000;
  localparam int BlockItems  = 25;
  localparam int RandBlocks  = 12;
  localparam int DirectedLen = 25;

  typedef struct {
    logic [31:0] ip;
    logic [31:0] fp;
    logic [4:0]  radix;
    logic [4:0]  lim;
    string       txt;   // empty: expected text comes from the predictor
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  rcv_in_t    num_in = '0;
  logic       char_valid;
  rcv_out_t   char_out;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i = '0;

  rcv_out_t   char_q[$];       // characters still owed by the block
  rcv_out_t   want;
  logic [4:0] frac_limit = FracDigitsMax;
  int         idle_pct = 0;
  int         errors = 0;
  int         cycles = 0;
  int         numbers_sent = 0;
  int         chars_seen = 0;
  int         limit_writes = 0;

  row_t plan [DirectedLen] = '{
    '{32'd0,         32'h0,         5'd10, 5'd20, "0"},
    '{32'hFFFFFFFF,  32'h0,         5'd16, 5'd20, "FFFFFFFF"},
    '{32'hFFFFFFFF,  32'h0,         5'd2,  5'd20, "11111111111111111111111111111111"},
    '{32'd0,         32'h80000000,  5'd2,  5'd20, "0.1"},
    '{32'd0,         32'h80000000,  5'd10, 5'd20, "0.5"},
    '{32'd10,        32'h0,         5'd16, 5'd20, "A"},
    '{32'd15,        32'h0,         5'd16, 5'd20, "F"},
    '{32'd255,       32'h0,         5'd0,  5'd20, "11111111"},
    '{32'd255,       32'h0,         5'd1,  5'd20, "11111111"},
    '{32'd255,       32'h0,         5'd17, 5'd20, "FF"},
    '{32'd255,       32'h0,         5'd31, 5'd20, "FF"},
    '{32'd12345,     32'h0,         5'd10, 5'd20, "12345"},
    '{32'd0,         32'h00000001,  5'd2,  5'd20, ""},
    '{32'd0,         32'hFFFFFFFF,  5'd16, 5'd20, "0.FFFFFFFF"},
    '{32'd1,         32'h40000000,  5'd10, 5'd20, "1.25"},
    '{32'd0,         32'h55555555,  5'd3,  5'd20, ""},
    '{32'hFFFFFFFF,  32'hFFFFFFFF,  5'd2,  5'd20, ""},
    '{32'd7,         32'h80000000,  5'd8,  5'd0,  "7."},
    '{32'd0,         32'h12345678,  5'd16, 5'd0,  "0."},
    '{32'd3,         32'h0,         5'd10, 5'd0,  "3"},
    '{32'd0,         32'h00000001,  5'd10, 5'd31, ""},
    '{32'd0,         32'h10000000,  5'd16, 5'd1,  "0.1"},
    '{32'd0,         32'h18000000,  5'd16, 5'd1,  "0.1"},
    '{32'd35,        32'h0,         5'd12, 5'd1,  "2B"},
    '{32'd0,         32'hAAAAAAAA,  5'd7,  5'd20, ""}
  };

  radix_string_converter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (num_in),
    .out_valid_o (char_valid),
    .out_o       (char_out),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [7:0] ascii_of(logic [3:0] d);
    if (d < 4'd10) begin
      return CharZero + {4'd0, d};
    end
    return CharA + {4'd0, d} - 8'd10;
  endfunction

  // Queues the characters the block must emit for one number.
  function automatic void predict_number(rcv_in_t it);
    logic [4:0]  b;
    logic [4:0]  lim;
    logic [31:0] ip;
    logic [31:0] rem;
    logic [31:0] fr;
    logic [63:0] prod;
    logic [3:0]  digs[$];
    rcv_out_t    chars[$];
    rcv_out_t    o;
    b = it.base;
    if (b < BaseMin) b = BaseMin;
    if (b > BaseMax) b = BaseMax;
    lim = (frac_limit > FracDigitsMax) ? FracDigitsMax : frac_limit;
    ip = it.int_part;
    do begin
      rem = ip % {27'd0, b};
      digs.push_front(rem[3:0]);
      ip = ip / {27'd0, b};
    end while (ip != 32'd0);
    o.last = 1'b0;
    foreach (digs[k]) begin
      o.char_code = ascii_of(digs[k]);
      chars.push_back(o);
    end
    fr = it.frac_part;
    if (fr != 32'd0) begin
      o.char_code = CharDot;
      chars.push_back(o);
      for (int k = 0; k < int'(lim) && fr != 32'd0; k++) begin
        prod = {32'd0, fr} * {59'd0, b};
        o.char_code = ascii_of(prod[35:32]);
        chars.push_back(o);
        fr = prod[31:0];
      end
    end
    chars[chars.size() - 1].last = 1'b1;
    foreach (chars[k]) char_q.push_back(chars[k]);
  endfunction

  function automatic void expect_text(string txt);
    rcv_out_t o;
    for (int k = 0; k < txt.len(); k++) begin
      o.char_code = txt[k];
      o.last = (k == txt.len() - 1);
      char_q.push_back(o);
    end
  endfunction

  function automatic rcv_in_t rand_number();
    rcv_in_t it;
    case ($urandom_range(3))
      0: it.int_part = 32'd0;
      1: it.int_part = $urandom_range(255);
      2: it.int_part = $urandom >> $urandom_range(31);
      default: it.int_part = $urandom;
    endcase
    case ($urandom_range(9))
      0, 1: it.frac_part = 32'd0;
      // only a few leading bits set: expansions that terminate early
      2, 3, 4: it.frac_part = $urandom & ~(32'hFFFFFFFF >> $urandom_range(1, 12));
      default: it.frac_part = $urandom;
    endcase
    if ($urandom_range(9) == 0) begin
      it.base = 5'($urandom_range(31));
    end else begin
      it.base = 5'($urandom_range(16, 2));
    end
    return it;
  endfunction

  // Called just after a falling edge; returns just after a falling edge with
  // start still high so a following item can go out back to back.
  task automatic send_number(rcv_in_t it, string txt);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    num_in <= it;
    do @(posedge clk_i); while (busy);
    if (txt.len() != 0) begin
      expect_text(txt);
    end else begin
      predict_number(it);
    end
    numbers_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk_i);
    while (char_q.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_digit_limit(logic [4:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    frac_limit = v;
    limit_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && char_valid) begin
      chars_seen++;
      if (char_q.size() == 0) begin
        errors++;
        $display("%0t: char %h last %b with nothing expected",
                 $time, char_out.char_code, char_out.last);
      end else begin
        want = char_q.pop_front();
        if (char_out.char_code !== want.char_code) begin
          errors++;
          $display("%0t: char_code expected %h got %h",
                   $time, want.char_code, char_out.char_code);
        end
        if (char_out.last !== want.last) begin
          errors++;
          $display("%0t: last expected %b got %b", $time, want.last, char_out.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timed out with %0d chars pending", $time, char_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rcv_in_t it;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows, starting from the reset digit limit
    idle_pct = 15;
    foreach (plan[r]) begin
      if (plan[r].lim != frac_limit) begin
        settle();
        write_digit_limit(plan[r].lim);
      end
      it.int_part  = plan[r].ip;
      it.frac_part = plan[r].fp;
      it.base      = plan[r].radix;
      send_number(it, plan[r].txt);
    end

    for (int blk = 0; blk < RandBlocks; blk++) begin
      idle_pct = (blk < 4) ? 15 : (blk < 8) ? 84 : 0;
      settle();
      case (blk)
        0: write_digit_limit(FracDigitsMax);
        1: write_digit_limit(5'd0);
        2: write_digit_limit(5'd31);
        default: write_digit_limit(5'($urandom_range(31)));
      endcase
      for (int k = 0; k < BlockItems; k++) begin
        send_number(rand_number(), "");
      end
    end

    settle();
    repeat (40) @(negedge clk_i);
    $display("Converted %0d numbers into %0d characters, digit limit written %0d times.",
             numbers_sent, chars_seen, limit_writes);
    $display("Bases 0..31, digit limits 0, 20 and 31 included, %0d mismatches.", errors);
    if (errors == 0 && char_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
